// ===== rtl/motor_drive_fault_protection_top_assert.svh =====
// Assertion macros for the fault protection block.
// Each macro takes a label, an antecedent and a consequent.
`ifndef MOTOR_DRIVE_FAULT_PROTECTION_TOP_ASSERT_SVH
`define MOTOR_DRIVE_FAULT_PROTECTION_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MDFP_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mdfp assertion failed");

`define MDFP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mdfp assertion failed");

`else

`define MDFP_ASSERT_SAME(name, ante, cons)

`define MDFP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== rtl/mdfp_pkg.sv =====
package mdfp_pkg;

   // Protection state codes.
   localparam logic [1:0] ST_OFF  = 2'd0;
   localparam logic [1:0] ST_OK   = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   // Kind of request beat carried on tuser.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // Drive control modes.
   localparam logic [1:0] MODE_STOPPED = 2'd0;
   localparam logic [1:0] MODE_RUNNING = 2'd1;

   // Configuration register indexes.
   localparam logic [2:0] REG_CURRENT_LIMIT  = 3'd0;
   localparam logic [2:0] REG_SPEED_LIMIT    = 3'd1;
   localparam logic [2:0] REG_VOLTAGE_HIGH   = 3'd2;
   localparam logic [2:0] REG_VOLTAGE_LOW    = 3'd3;
   localparam logic [2:0] REG_TEMP_LIMIT     = 3'd4;
   localparam logic [2:0] REG_FAULT_MASK_LOW = 3'd5;
   localparam logic [2:0] REG_FAULT_MASK_HI  = 3'd6;

   localparam logic [15:0] POWERUP_TICKS = 16'd5000;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

   // Fault bit positions in the low word.
   localparam int unsigned FL_TRIP     = 0;
   localparam int unsigned FL_DC_HIGH  = 1;
   localparam int unsigned FL_DC_LOW   = 2;
   localparam int unsigned FL_TEMP     = 3;
   localparam int unsigned FL_RESTORE  = 4;
   // Fault bit positions in the high word.
   localparam int unsigned FH_SWITCH   = 0;
   localparam int unsigned FH_CURRENT  = 4;
   localparam int unsigned FH_SPEED    = 7;

   localparam int unsigned REQ_DATA_W = 208;
   localparam int unsigned RSP_DATA_W = 48;

   // Request payload, last declared field in the lowest bits.
   typedef struct packed {
      logic [5:0]         pad;
      logic               restore_error;
      logic               reset_request;
      logic [1:0]         control_mode;
      logic signed [31:0] temperature;
      logic signed [31:0] dc_voltage;
      logic signed [31:0] motor_speed;
      logic signed [31:0] current_c;
      logic signed [31:0] current_b;
      logic signed [31:0] current_a;
      logic [4:0]         driver_faults_n;
      logic               pwm_fault;
   } req_fields_type;

   // Result payload, last declared field in the lowest bits.
   typedef struct packed {
      logic [2:0]  pad;
      logic [5:0]  log_code;
      logic        log_valid;
      logic [15:0] masked_faults_high;
      logic [15:0] masked_faults_low;
      logic        clear_driver_fault;
      logic        clear_commands;
      logic        pwm_off;
      logic        fault_indicator;
      logic [1:0]  prot_state;
   } rsp_fields_type;

endpackage

// ===== rtl/motor_drive_fault_protection_top.sv =====
// Motor drive fault protection supervisor.
//
// Request beats arrive on the req_ stream. tuser selects the kind of beat:
// a fast protection sample latches sticky faults, masks them and runs the
// off/ok/fail state machine; a millisecond tick scans one of the 32 masked
// fault bits and reports a newly set one as a log code. Every request beat
// gives exactly one response beat on the rsp_ stream.
// A beat passes an input register and then the response register, which
// holds its response. One beat is taken every cycle while the receiver
// takes the responses; the supervisor state is updated once per beat in
// the cycle the beat moves into the response register.
// The user writes limits and fault masks through the csr_ port only while no
// beat is in flight; the block itself does not enforce this.
// Reset clears the pipeline and all fault state and puts the supervisor in
// off, where it clears the faults and counts fast samples before moving to
// ok. When the receiver holds rsp_tready low, the response register holds
// its beat, the input register fills, and req_tready then drops.
`include "motor_drive_fault_protection_top_assert.svh"

module motor_drive_fault_protection_top
   import mdfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pwm_fault, driver_faults_n, current_a, current_b, current_c,
   // motor_speed, dc_voltage, temperature, control_mode, reset_request,
   // restore_error, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // prot_state, fault_indicator, pwm_off, clear_commands,
   // clear_driver_fault, masked_faults_low, masked_faults_high, log_valid,
   // log_code, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   // Configuration registers.
   logic [30:0]        current_limit_ff;
   logic [30:0]        speed_limit_ff;
   logic signed [31:0] voltage_high_ff;
   logic signed [31:0] voltage_low_ff;
   logic signed [31:0] temp_limit_ff;
   logic [15:0]        mask_low_ff;
   logic [15:0]        mask_high_ff;

   // Pipeline.
   logic               s1_valid_ff;
   logic               s1_func_ff;
   req_fields_type     s1_data_ff;
   logic               s1_adv;
   logic               rsp_valid_ff;
   rsp_fields_type     rsp_data_ff;
   rsp_fields_type     rsp_data_in;

   // Supervisor state.
   logic [1:0]  prot_mode_ff, prot_mode_in;
   logic        entry_pending_ff, entry_pending_in;
   logic [15:0] powerup_count_ff, powerup_count_in;
   logic [15:0] fault_low_ff, fault_low_in;
   logic [15:0] fault_high_ff, fault_high_in;
   logic [15:0] masked_low_ff, masked_low_in;
   logic [15:0] masked_high_ff, masked_high_in;
   logic [15:0] logged_low_ff, logged_low_in;
   logic [15:0] logged_high_ff, logged_high_in;
   logic [4:0]  scan_index_ff, scan_index_in;
   logic        fault_ind_ff, fault_ind_in;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         current_limit_ff <= '0;
         speed_limit_ff   <= '0;
         voltage_high_ff  <= '0;
         voltage_low_ff   <= '0;
         temp_limit_ff    <= '0;
         mask_low_ff      <= '0;
         mask_high_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_CURRENT_LIMIT:  current_limit_ff <= csr_wdata[30:0];
            REG_SPEED_LIMIT:    speed_limit_ff   <= csr_wdata[30:0];
            REG_VOLTAGE_HIGH:   voltage_high_ff  <= csr_wdata;
            REG_VOLTAGE_LOW:    voltage_low_ff   <= csr_wdata;
            REG_TEMP_LIMIT:     temp_limit_ff    <= csr_wdata;
            REG_FAULT_MASK_LOW: mask_low_ff      <= csr_wdata[15:0];
            REG_FAULT_MASK_HI:  mask_high_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [32:0] lim_pos;
      logic signed [32:0] lim_neg;
      logic signed [32:0] ia, ib, ic, spd, spd_abs;
      logic [15:0]        fwl, fwh;
      logic [15:0]        sel_word, sel_logged;
      logic [3:0]         bit_pos;
      logic               entry, rst, trip_en;

      lim_pos  = {2'b00, current_limit_ff};
      lim_neg  = -lim_pos;
      ia       = {s1_data_ff.current_a[31], s1_data_ff.current_a};
      ib       = {s1_data_ff.current_b[31], s1_data_ff.current_b};
      ic       = {s1_data_ff.current_c[31], s1_data_ff.current_c};
      spd      = {s1_data_ff.motor_speed[31], s1_data_ff.motor_speed};
      spd_abs  = spd[32] ? -spd : spd;
      fwl      = fault_low_ff;
      fwh      = fault_high_ff;
      entry    = entry_pending_ff;
      rst      = s1_data_ff.reset_request;
      trip_en  = s1_data_ff.control_mode != MODE_STOPPED &&
                 s1_data_ff.control_mode != MODE_RUNNING;
      bit_pos  = scan_index_ff[3:0];
      sel_word   = scan_index_ff[4] ? masked_high_ff : masked_low_ff;
      sel_logged = scan_index_ff[4] ? logged_high_ff : logged_low_ff;

      prot_mode_in     = prot_mode_ff;
      entry_pending_in = entry_pending_ff;
      powerup_count_in = powerup_count_ff;
      fault_low_in     = fault_low_ff;
      fault_high_in    = fault_high_ff;
      masked_low_in    = masked_low_ff;
      masked_high_in   = masked_high_ff;
      logged_low_in    = logged_low_ff;
      logged_high_in   = logged_high_ff;
      scan_index_in    = scan_index_ff;
      fault_ind_in     = fault_ind_ff;
      rsp_data_in      = '0;

      if (s1_func_ff == FUNC_TICK) begin
         if (sel_word[bit_pos]) begin
            if (!sel_logged[bit_pos]) begin
               rsp_data_in.log_valid = 1'b1;
               rsp_data_in.log_code  = {1'b0, scan_index_ff} + 6'd1;
               sel_logged[bit_pos]   = 1'b1;
            end
         end else begin
            sel_logged[bit_pos] = 1'b0;
         end
         if (scan_index_ff[4]) begin
            logged_high_in = sel_logged;
         end else begin
            logged_low_in = sel_logged;
         end
         scan_index_in = scan_index_ff + 5'd1;
         if (s1_data_ff.restore_error) begin
            fault_low_in[FL_RESTORE] = 1'b1;
         end
      end else begin
         if ((s1_data_ff.pwm_fault && trip_en) || !s1_data_ff.driver_faults_n[0]) begin
            fwl[FL_TRIP] = 1'b1;
         end
         fwh[FH_SWITCH +: 4] = fwh[FH_SWITCH +: 4] | ~s1_data_ff.driver_faults_n[4:1];
         if (ia > lim_pos || ia < lim_neg) fwh[FH_CURRENT]     = 1'b1;
         if (ib > lim_pos || ib < lim_neg) fwh[FH_CURRENT + 1] = 1'b1;
         if (ic > lim_pos || ic < lim_neg) fwh[FH_CURRENT + 2] = 1'b1;
         if (spd_abs > {2'b00, speed_limit_ff}) fwh[FH_SPEED] = 1'b1;
         if (s1_data_ff.dc_voltage > voltage_high_ff) fwl[FL_DC_HIGH] = 1'b1;
         if (s1_data_ff.dc_voltage < voltage_low_ff &&
             s1_data_ff.control_mode != MODE_STOPPED) begin
            fwl[FL_DC_LOW] = 1'b1;
         end
         if (s1_data_ff.temperature > temp_limit_ff) fwl[FL_TEMP] = 1'b1;

         masked_low_in    = fwl & mask_low_ff;
         masked_high_in   = fwh & mask_high_ff;
         entry_pending_in = 1'b0;
         fault_low_in     = fwl;
         fault_high_in    = fwh;

         case (prot_mode_ff)
            ST_OK: begin
               if (entry) fault_ind_in = 1'b0;
               if ((masked_low_in | masked_high_in) != 16'd0) begin
                  prot_mode_in     = ST_FAIL;
                  entry_pending_in = 1'b1;
               end
            end
            ST_FAIL: begin
               if (entry) rsp_data_in.clear_commands = 1'b1;
               fault_ind_in        = 1'b1;
               rsp_data_in.pwm_off = 1'b1;
               if (rst) begin
                  prot_mode_in                   = ST_OK;
                  entry_pending_in               = 1'b1;
                  rsp_data_in.clear_driver_fault = 1'b1;
                  rsp_data_in.clear_commands     = 1'b1;
                  fault_low_in                   = '0;
                  fault_high_in                  = '0;
               end
            end
            default: begin
               // Off, and the unused code, hold the faults clear while the
               // power-up count runs.
               fault_low_in  = '0;
               fault_high_in = '0;
               if (powerup_count_ff != COUNT_MAX) begin
                  powerup_count_in = powerup_count_ff + 16'd1;
               end
               if (powerup_count_ff > POWERUP_TICKS || powerup_count_ff == COUNT_MAX) begin
                  prot_mode_in     = ST_OK;
                  entry_pending_in = 1'b1;
               end
            end
         endcase
      end

      rsp_data_in.prot_state         = prot_mode_in;
      rsp_data_in.fault_indicator    = fault_ind_in;
      rsp_data_in.masked_faults_low  = masked_low_in;
      rsp_data_in.masked_faults_high = masked_high_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         prot_mode_ff     <= ST_OFF;
         entry_pending_ff <= 1'b1;
         powerup_count_ff <= '0;
         fault_low_ff     <= '0;
         fault_high_ff    <= '0;
         masked_low_ff    <= '0;
         masked_high_ff   <= '0;
         logged_low_ff    <= '0;
         logged_high_ff   <= '0;
         scan_index_ff    <= '0;
         fault_ind_ff     <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_adv) begin
            rsp_valid_ff     <= 1'b1;
            prot_mode_ff     <= prot_mode_in;
            entry_pending_ff <= entry_pending_in;
            powerup_count_ff <= powerup_count_in;
            fault_low_ff     <= fault_low_in;
            fault_high_ff    <= fault_high_in;
            masked_low_ff    <= masked_low_in;
            masked_high_ff   <= masked_high_in;
            logged_low_ff    <= logged_low_in;
            logged_high_ff   <= logged_high_in;
            scan_index_ff    <= scan_index_in;
            fault_ind_ff     <= fault_ind_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_func_ff <= req_tuser;
         s1_data_ff <= req_tdata;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `MDFP_ASSERT_SAME(a_tick_no_drive_cmd,
      rsp_tvalid && rsp_data_ff.log_valid,
      !rsp_data_ff.pwm_off && !rsp_data_ff.clear_commands && !rsp_data_ff.clear_driver_fault)
   `MDFP_ASSERT_SAME(a_drv_clear_to_ok,
      rsp_tvalid && rsp_data_ff.clear_driver_fault,
      rsp_data_ff.prot_state == ST_OK && rsp_data_ff.clear_commands)
   `MDFP_ASSERT_SAME(a_pwm_off_flags_fault,
      rsp_tvalid && rsp_data_ff.pwm_off,
      rsp_data_ff.fault_indicator)
   `MDFP_ASSERT_NEXT(a_fail_holds,
      s1_adv && s1_func_ff == FUNC_SAMPLE && prot_mode_ff == ST_FAIL &&
      !s1_data_ff.reset_request,
      prot_mode_ff == ST_FAIL)

endmodule

// ===== tb/sv/tb_motor_drive_fault_protection_top.sv =====
module tb_motor_drive_fault_protection_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mdfp_pkg::*;

   localparam logic [1:0] MODE_OTHER = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam int unsigned PHASE_BEATS = 130;

   class supervisor_checker;
      logic [30:0]        current_lim;
      logic [30:0]        speed_lim;
      logic signed [31:0] volt_high_lim;
      logic signed [31:0] volt_low_lim;
      logic signed [31:0] temp_lim;
      logic [15:0]        mask_low;
      logic [15:0]        mask_high;
      logic [1:0]         prot_mode;
      bit                 entry_pending;
      logic [15:0]        powerup_count;
      logic [15:0]        faults_low;
      logic [15:0]        faults_high;
      logic [15:0]        masked_low;
      logic [15:0]        masked_high;
      logic [31:0]        logged;
      logic [4:0]         scan_index;
      bit                 fault_flag;
      rsp_fields_type     expected_status[$];
      int                 failures;

      function new();
         current_lim = '0;
         speed_lim = '0;
         volt_high_lim = '0;
         volt_low_lim = '0;
         temp_lim = '0;
         mask_low = '0;
         mask_high = '0;
         prot_mode = ST_OFF;
         entry_pending = 1'b1;
         powerup_count = '0;
         faults_low = '0;
         faults_high = '0;
         masked_low = '0;
         masked_high = '0;
         logged = '0;
         scan_index = '0;
         fault_flag = 1'b0;
         failures = 0;
      endfunction

      function void write_register(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_CURRENT_LIMIT:  current_lim = value[30:0];
            REG_SPEED_LIMIT:    speed_lim = value[30:0];
            REG_VOLTAGE_HIGH:   volt_high_lim = value;
            REG_VOLTAGE_LOW:    volt_low_lim = value;
            REG_TEMP_LIMIT:     temp_lim = value;
            REG_FAULT_MASK_LOW: mask_low = value[15:0];
            REG_FAULT_MASK_HI:  mask_high = value[15:0];
            default: ;
         endcase
      endfunction

      function rsp_fields_type supervise_step(logic func, req_fields_type r);
         rsp_fields_type o;
         longint ia, ib, ic, spd, udc, tmp, ilim, slim;
         logic [31:0] masked_all;
         logic [15:0] old_count;
         bit entry;
         o = '0;
         if (func == FUNC_TICK) begin
            masked_all = {masked_high, masked_low};
            if (masked_all[scan_index]) begin
               if (!logged[scan_index]) begin
                  o.log_valid = 1'b1;
                  o.log_code = {1'b0, scan_index} + 6'd1;
                  logged[scan_index] = 1'b1;
               end
            end else begin
               logged[scan_index] = 1'b0;
            end
            scan_index = scan_index + 5'd1;
            if (r.restore_error) faults_low[FL_RESTORE] = 1'b1;
         end else begin
            ia = longint'($signed(r.current_a));
            ib = longint'($signed(r.current_b));
            ic = longint'($signed(r.current_c));
            spd = longint'($signed(r.motor_speed));
            udc = longint'($signed(r.dc_voltage));
            tmp = longint'($signed(r.temperature));
            ilim = longint'(current_lim);
            slim = longint'(speed_lim);
            if (spd < 0) spd = -spd;

            if (r.pwm_fault && r.control_mode != MODE_STOPPED &&
                r.control_mode != MODE_RUNNING)
               faults_low[FL_TRIP] = 1'b1;
            if (!r.driver_faults_n[0]) faults_low[FL_TRIP] = 1'b1;
            for (int k = 0; k < 4; k++)
               if (!r.driver_faults_n[k + 1]) faults_high[FH_SWITCH + k] = 1'b1;
            if (ia > ilim || ia < -ilim) faults_high[FH_CURRENT] = 1'b1;
            if (ib > ilim || ib < -ilim) faults_high[FH_CURRENT + 1] = 1'b1;
            if (ic > ilim || ic < -ilim) faults_high[FH_CURRENT + 2] = 1'b1;
            if (spd > slim) faults_high[FH_SPEED] = 1'b1;
            if (udc > longint'(volt_high_lim)) faults_low[FL_DC_HIGH] = 1'b1;
            if (udc < longint'(volt_low_lim) && r.control_mode != MODE_STOPPED)
               faults_low[FL_DC_LOW] = 1'b1;
            if (tmp > longint'(temp_lim)) faults_low[FL_TEMP] = 1'b1;

            masked_low = faults_low & mask_low;
            masked_high = faults_high & mask_high;
            entry = entry_pending;
            entry_pending = 1'b0;

            case (prot_mode)
               ST_OK: begin
                  if (entry) fault_flag = 1'b0;
                  if ((masked_low | masked_high) != '0) begin
                     prot_mode = ST_FAIL;
                     entry_pending = 1'b1;
                  end
               end
               ST_FAIL: begin
                  if (entry) o.clear_commands = 1'b1;
                  fault_flag = 1'b1;
                  o.pwm_off = 1'b1;
                  if (r.reset_request) begin
                     prot_mode = ST_OK;
                     entry_pending = 1'b1;
                     o.clear_driver_fault = 1'b1;
                     o.clear_commands = 1'b1;
                     faults_low = '0;
                     faults_high = '0;
                  end
               end
               default: begin
                  // Off clears the faults every sample and counts toward power-up.
                  old_count = powerup_count;
                  faults_low = '0;
                  faults_high = '0;
                  if (powerup_count != COUNT_MAX) powerup_count = powerup_count + 16'd1;
                  if (old_count > POWERUP_TICKS || old_count == COUNT_MAX) begin
                     prot_mode = ST_OK;
                     entry_pending = 1'b1;
                  end
               end
            endcase
         end
         o.prot_state = prot_mode;
         o.fault_indicator = fault_flag;
         o.masked_faults_low = masked_low;
         o.masked_faults_high = masked_high;
         return o;
      endfunction

      function void note_request(logic func, req_fields_type r);
         expected_status.push_back(supervise_step(func, r));
      endfunction

      function void compare(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_fields_type got);
         rsp_fields_type want;
         if (expected_status.size() == 0) begin
            failures++;
            if (failures <= 10) $display("%0t: response beat %h with none pending", $time, got);
            return;
         end
         want = expected_status.pop_front();
         compare("prot_state", 16'(want.prot_state), 16'(got.prot_state));
         compare("fault_indicator", 16'(want.fault_indicator), 16'(got.fault_indicator));
         compare("pwm_off", 16'(want.pwm_off), 16'(got.pwm_off));
         compare("clear_commands", 16'(want.clear_commands), 16'(got.clear_commands));
         compare("clear_driver_fault", 16'(want.clear_driver_fault),
                 16'(got.clear_driver_fault));
         compare("masked_faults_low", want.masked_faults_low, got.masked_faults_low);
         compare("masked_faults_high", want.masked_faults_high, got.masked_faults_high);
         compare("log_valid", 16'(want.log_valid), 16'(got.log_valid));
         compare("log_code", 16'(want.log_code), 16'(got.log_code));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [2:0]            csr_index;
   logic [31:0]           csr_wdata;

   supervisor_checker sb = new();
   logic [31:0] csr_image [7];
   bit steady;
   bit hold_rsp;

   motor_drive_fault_protection_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly in-range values; now and then a value on or just past an edge.
   function automatic logic [31:0] pick_sample(longint lo, longint hi);
      longint v;
      if ($urandom_range(0, 99) < 92) begin
         v = lo + longint'($urandom_range(0, 32'(hi - lo)));
      end else begin
         case ($urandom_range(0, 5))
            0: v = lo - 1;
            1: v = lo;
            2: v = hi;
            3: v = hi + 1;
            4: v = longint'($urandom());
            default: v = $urandom_range(0, 1) ? 64'h7FFF_FFFF : 64'h8000_0000;
         endcase
      end
      return v[31:0];
   endfunction

   function automatic req_fields_type random_request();
      req_fields_type r;
      longint ilim, slim, vlo, vhi;
      ilim = longint'(sb.current_lim);
      slim = longint'(sb.speed_lim);
      vlo = longint'(sb.volt_low_lim);
      vhi = longint'(sb.volt_high_lim);
      if (vlo > vhi) begin
         vlo = vhi;
         vhi = longint'(sb.volt_low_lim);
      end
      r = '0;
      r.pwm_fault = ($urandom_range(0, 9) == 0);
      r.driver_faults_n = ($urandom_range(0, 9) == 0) ? 5'($urandom()) : 5'h1F;
      r.current_a = pick_sample(-ilim, ilim);
      r.current_b = pick_sample(-ilim, ilim);
      r.current_c = pick_sample(-ilim, ilim);
      r.motor_speed = pick_sample(-slim, slim);
      // The most negative code lies outside the speed range.
      if (r.motor_speed == 32'sh8000_0000) r.motor_speed = 32'sh8000_0001;
      r.dc_voltage = pick_sample(vlo, vhi);
      r.temperature = pick_sample(-64'sd2147483648, longint'(sb.temp_lim));
      r.control_mode = 2'($urandom_range(0, 2));
      r.reset_request = ($urandom_range(0, 4) == 0);
      r.restore_error = ($urandom_range(0, 24) == 0);
      return r;
   endfunction

   function automatic req_fields_type quiet_request();
      req_fields_type r;
      r = '0;
      r.driver_faults_n = 5'h1F;
      r.dc_voltage = 32'sd400;
      r.temperature = 32'sd25;
      r.control_mode = MODE_RUNNING;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic func, req_fields_type r);
      while (!steady && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(func, r);
      @(negedge clock);
   endtask

   task automatic send_random();
      send_request(($urandom_range(0, 4) == 0) ? FUNC_TICK : FUNC_SAMPLE, random_request());
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_status.size() != 0) @(negedge clock);
   endtask

   task automatic load_settings();
      for (int i = REG_CURRENT_LIMIT; i <= REG_FAULT_MASK_HI; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= csr_image[i];
         sb.write_register(3'(i), csr_image[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic choose_settings(int phase);
      csr_image[REG_CURRENT_LIMIT] = 32'd1000;
      csr_image[REG_SPEED_LIMIT] = 32'd3000;
      csr_image[REG_VOLTAGE_HIGH] = 32'd700;
      csr_image[REG_VOLTAGE_LOW] = 32'd200;
      csr_image[REG_TEMP_LIMIT] = 32'd85;
      csr_image[REG_FAULT_MASK_LOW] = 32'hFFFF;
      csr_image[REG_FAULT_MASK_HI] = 32'hFFFF;
      case (phase)
         1: begin
            csr_image[REG_CURRENT_LIMIT] = 32'h7FFF_FFFF;
            csr_image[REG_SPEED_LIMIT] = 32'h7FFF_FFFF;
            csr_image[REG_VOLTAGE_HIGH] = 32'h7FFF_FFFF;
            csr_image[REG_VOLTAGE_LOW] = 32'h8000_0000;
            csr_image[REG_TEMP_LIMIT] = 32'h7FFF_FFFF;
         end
         2: begin
            foreach (csr_image[i]) csr_image[i] = '0;
         end
         3: begin
            csr_image[REG_CURRENT_LIMIT] = $urandom() >> 1;
            csr_image[REG_SPEED_LIMIT] = $urandom() >> 1;
            csr_image[REG_VOLTAGE_HIGH] = $urandom();
            csr_image[REG_VOLTAGE_LOW] = $urandom();
            csr_image[REG_TEMP_LIMIT] = $urandom();
            csr_image[REG_FAULT_MASK_LOW] = $urandom_range(0, 16'hFFFF);
            csr_image[REG_FAULT_MASK_HI] = $urandom_range(0, 16'hFFFF);
         end
         4: begin
            csr_image[REG_CURRENT_LIMIT] = $urandom_range(0, 50);
            csr_image[REG_FAULT_MASK_LOW] = $urandom_range(0, 16'hFFFF);
            csr_image[REG_FAULT_MASK_HI] = $urandom_range(0, 16'hFFFF);
         end
         default: ;
      endcase
   endtask

   // Runs with the typical limits, starting in ok.
   task automatic run_directed();
      req_fields_type r;
      r = quiet_request();
      send_request(FUNC_SAMPLE, r);
      send_request(FUNC_TICK, r);
      // Values sitting exactly on their limits must not trip.
      r.current_a = 32'sd1000;
      r.current_b = -32'sd1000;
      r.motor_speed = -32'sd3000;
      r.dc_voltage = 32'sd700;
      r.temperature = 32'sd85;
      send_request(FUNC_SAMPLE, r);
      // Undervoltage is ignored while stopped; a PWM trip counts only in other modes.
      r = quiet_request();
      r.dc_voltage = 32'sh8000_0000;
      r.control_mode = MODE_STOPPED;
      r.pwm_fault = 1'b1;
      send_request(FUNC_SAMPLE, r);
      r.control_mode = MODE_RUNNING;
      r.dc_voltage = 32'sd400;
      send_request(FUNC_SAMPLE, r);
      r.control_mode = MODE_SPARE;
      send_request(FUNC_SAMPLE, r);
      r = quiet_request();
      send_request(FUNC_SAMPLE, r);
      send_request(FUNC_TICK, r);
      send_request(FUNC_TICK, r);
      r.reset_request = 1'b1;
      send_request(FUNC_SAMPLE, r);
      r = quiet_request();
      r.current_c = 32'sh8000_0000;
      send_request(FUNC_SAMPLE, r);
      r = quiet_request();
      r.current_a = 32'sh7FFF_FFFF;
      r.reset_request = 1'b1;
      send_request(FUNC_SAMPLE, r);
      r = quiet_request();
      r.motor_speed = -32'sd2147483647;
      send_request(FUNC_SAMPLE, r);
      // A restore error on a sample beat is ignored; on a tick it latches.
      r = quiet_request();
      r.restore_error = 1'b1;
      r.reset_request = 1'b1;
      send_request(FUNC_SAMPLE, r);
      r.reset_request = 1'b0;
      send_request(FUNC_TICK, r);
      r = quiet_request();
      send_request(FUNC_SAMPLE, r);
      r.reset_request = 1'b1;
      send_request(FUNC_SAMPLE, r);
      r = quiet_request();
      r.dc_voltage = 32'sd701;
      r.temperature = 32'sd86;
      send_request(FUNC_SAMPLE, r);
      r = quiet_request();
      r.dc_voltage = 32'sd199;
      r.reset_request = 1'b1;
      send_request(FUNC_SAMPLE, r);
      r = '0;
      r.pwm_fault = 1'b1;
      r.current_a = 32'sh7FFF_FFFF;
      r.current_b = 32'sh7FFF_FFFF;
      r.current_c = 32'sh7FFF_FFFF;
      r.motor_speed = 32'sh7FFF_FFFF;
      r.dc_voltage = 32'sh7FFF_FFFF;
      r.temperature = 32'sh7FFF_FFFF;
      r.control_mode = MODE_OTHER;
      r.restore_error = 1'b1;
      send_request(FUNC_SAMPLE, r);
      r = '0;
      send_request(FUNC_SAMPLE, r);
      r.reset_request = 1'b1;
      send_request(FUNC_SAMPLE, r);
   endtask

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 9);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_fields_type'(rsp_tdata));
   end

   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_SAMPLE;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_CURRENT_LIMIT;
      csr_wdata = '0;
      steady = 1'b0;
      hold_rsp = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      choose_settings(0);
      load_settings();
      // The supervisor leaves off only after the power-up count runs out.
      while (sb.prot_mode == ST_OFF) send_random();
      run_directed();

      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         choose_settings(phase);
         load_settings();
         steady = (phase == 2);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if (phase == 1 && k == 50) hold_rsp = 1'b1;
            send_random();
         end
      end
      wait_drained();
      steady = 1'b0;
      repeat (8) @(posedge clock);

      if (sb.failures == 0 && sb.expected_status.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
